/* sv/gatd_pkg.sv */
// gatd_pkg: shared types, codes and helpers of the goose alldata tlv decoder
// depends on nothing; used by every module of the block
package gatd_pkg;

  localparam int MAX_STRING_BYTES_DEF = 32;
  // byte counts of a kept string fit in this width for every legal string size
  localparam int KEPT_W = 9;

  // value kinds
  localparam logic [4:0] K_NONE   = 5'd0;
  localparam logic [4:0] K_STRUCT = 5'd1;
  localparam logic [4:0] K_BOOL   = 5'd2;
  localparam logic [4:0] K_INT8   = 5'd3;
  localparam logic [4:0] K_UINT8  = 5'd7;
  localparam logic [4:0] K_F32    = 5'd11;
  localparam logic [4:0] K_F64    = 5'd12;
  localparam logic [4:0] K_BITS   = 5'd13;
  localparam logic [4:0] K_ETIME  = 5'd14;
  localparam logic [4:0] K_TSTAMP = 5'd15;
  localparam logic [4:0] K_ARRAY  = 5'd16;
  localparam logic [4:0] K_OCTET  = 5'd17;
  localparam logic [4:0] K_VIS    = 5'd18;
  localparam logic [4:0] K_UNI    = 5'd19;
  localparam logic [4:0] K_LENERR = 5'd20;
  localparam logic [4:0] K_TRUNC  = 5'd21;

  // element tags
  localparam logic [7:0] TAG_STRUCT = 8'hA2;
  localparam logic [7:0] TAG_BOOL   = 8'h83;
  localparam logic [7:0] TAG_BITS   = 8'h84;
  localparam logic [7:0] TAG_INT    = 8'h85;
  localparam logic [7:0] TAG_UINT   = 8'h86;
  localparam logic [7:0] TAG_FLOAT  = 8'h87;
  localparam logic [7:0] TAG_ETIME  = 8'h8C;
  localparam logic [7:0] TAG_TSTAMP = 8'h91;
  localparam logic [7:0] TAG_ARRAY  = 8'h81;
  localparam logic [7:0] TAG_OCTET  = 8'h89;
  localparam logic [7:0] TAG_VIS    = 8'h8A;
  localparam logic [7:0] TAG_UNI    = 8'h90;

  // length forms
  localparam logic [7:0] LEN_LONG  = 8'h80;
  localparam logic [7:0] LEN_ONE   = 8'h81;
  localparam logic [7:0] LEN_TWO   = 8'h82;
  localparam logic [7:0] SIGN_BYTE = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } req_t;

  typedef struct packed {
    logic [4:0]  value_kind;
    logic [63:0] value_word;
    logic [5:0]  word_index;
    logic        run_last;
    logic        data_done;
  } res_t;

  // result group of one request, parser to emitter
  typedef struct packed {
    logic              valid;
    logic [4:0]        kind;
    logic [63:0]       word;
    logic              is_str;
    logic [KEPT_W-1:0] kept;
    logic              done;
  } desc_t;

  // string store byte write
  typedef struct packed {
    logic              en;
    logic [KEPT_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = b[i];
    return r;
  endfunction

  function automatic logic [4:0] width_kind(input logic [4:0] base, input logic [15:0] n);
    logic [4:0] k;
    if (n <= 16'd1) k = base;
    else if (n == 16'd2) k = base + 5'd1;
    else if (n <= 16'd4) k = base + 5'd2;
    else k = base + 5'd3;
    return k;
  endfunction

endpackage

/* sv/gatd_parser.sv */
// gatd_parser: tag-length-value parse state and per-byte decode
// depends on gatd_pkg; writes string bytes to the emitter's store
module gatd_parser #(
  parameter int MAX_STRING_BYTES = gatd_pkg::MAX_STRING_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  gatd_pkg::req_t req,
  output gatd_pkg::desc_t desc,
  output gatd_pkg::wr_t   wr
);

  typedef enum logic [1:0] {PH_TAG, PH_LEN, PH_LONG, PH_BODY} phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  tag, tag_next;
  logic [1:0]  lbl, lbl_next;
  logic [15:0] cl, cl_next;
  logic [15:0] cs, cs_next;
  logic [63:0] acc, acc_next;
  logic        sf, sf_next;
  logic        discard, discard_next;

  logic        start, fin, fin_sf;
  logic [15:0] fin_len, eff;
  logic [63:0] fin_acc;
  logic [7:0]  b;

  assign b = req.data_byte;

  always_comb begin
    phase_next = phase; tag_next = tag; lbl_next = lbl; cl_next = cl;
    cs_next = cs; acc_next = acc; sf_next = sf; discard_next = discard;
    start = 1'b0; fin = 1'b0;
    fin_len = cs; fin_acc = acc; fin_sf = sf;
    eff = '0;
    desc = '0;
    wr = '0;
    wr.data = b;
    wr.addr = gatd_pkg::KEPT_W'(cs);
    if (!discard) begin
      case (phase)
        PH_TAG: begin
          tag_next = b;
          phase_next = PH_LEN;
        end
        PH_LEN: begin
          if (b < gatd_pkg::LEN_LONG) begin
            cl_next = {8'h00, b};
            start = 1'b1;
          end else if (b == gatd_pkg::LEN_ONE || b == gatd_pkg::LEN_TWO) begin
            lbl_next = b[1:0];
            cl_next = '0;
            phase_next = PH_LONG;
          end else begin
            desc.valid = 1'b1;
            desc.kind = gatd_pkg::K_LENERR;
            discard_next = 1'b1;
            phase_next = PH_TAG;
          end
        end
        PH_LONG: begin
          cl_next = {cl[7:0], b};
          lbl_next = lbl - 2'd1;
          if (lbl == 2'd1) start = 1'b1;
        end
        PH_BODY: begin
          case (tag)
            gatd_pkg::TAG_INT: begin
              if (cs == 16'd0 && b == gatd_pkg::SIGN_BYTE) sf_next = 1'b1;
              else acc_next = {acc[55:0], b};
            end
            gatd_pkg::TAG_BOOL, gatd_pkg::TAG_UINT, gatd_pkg::TAG_ETIME,
            gatd_pkg::TAG_TSTAMP: acc_next = {acc[55:0], b};
            gatd_pkg::TAG_FLOAT: if (cs >= 16'd1) acc_next = {acc[55:0], b};
            gatd_pkg::TAG_BITS: begin
              if (cs >= 16'd1 && cs <= 16'd4)
                acc_next = acc | (64'(gatd_pkg::rev8(b)) << {cs[2:0] - 3'd1, 3'b000});
            end
            gatd_pkg::TAG_ARRAY, gatd_pkg::TAG_OCTET, gatd_pkg::TAG_VIS,
            gatd_pkg::TAG_UNI: wr.en = fire && (cs < 16'(MAX_STRING_BYTES - 1));
            default: ;
          endcase
          cs_next = cs + 16'd1;
          cl_next = cl - 16'd1;
          if (cl == 16'd1) begin
            fin = 1'b1;
            fin_len = cs_next;
            fin_acc = acc_next;
            fin_sf = sf_next;
          end
        end
        default: phase_next = PH_TAG;
      endcase
    end

    if (start) begin
      cs_next = '0; acc_next = '0; sf_next = 1'b0;
      if (tag == gatd_pkg::TAG_STRUCT) begin
        desc.valid = 1'b1;
        desc.kind = gatd_pkg::K_STRUCT;
        phase_next = PH_TAG;
      end else if (cl_next == 16'd0) begin
        fin = 1'b1; fin_len = '0; fin_acc = '0; fin_sf = 1'b0;
      end else begin
        phase_next = PH_BODY;
      end
    end

    if (fin) begin
      phase_next = PH_TAG;
      desc.valid = 1'b1;
      desc.kind = gatd_pkg::K_NONE;
      eff = fin_len - 16'(fin_sf);
      case (tag)
        gatd_pkg::TAG_BOOL, gatd_pkg::TAG_ETIME, gatd_pkg::TAG_TSTAMP: begin
          if (fin_len <= 16'd8) begin
            desc.kind = (tag == gatd_pkg::TAG_BOOL) ? gatd_pkg::K_BOOL :
                        (tag == gatd_pkg::TAG_ETIME) ? gatd_pkg::K_ETIME : gatd_pkg::K_TSTAMP;
            desc.word = fin_acc;
          end
        end
        gatd_pkg::TAG_INT: begin
          if (eff <= 16'd8) begin
            desc.kind = gatd_pkg::width_kind(gatd_pkg::K_INT8, eff);
            desc.word = (fin_sf && eff < 16'd8) ?
                        (fin_acc | (~64'd0 << {eff[2:0], 3'b000})) : fin_acc;
          end
        end
        gatd_pkg::TAG_UINT: begin
          if (fin_len <= 16'd8) begin
            desc.kind = gatd_pkg::width_kind(gatd_pkg::K_UINT8, fin_len);
            desc.word = fin_acc;
          end
        end
        gatd_pkg::TAG_FLOAT: begin
          if (fin_len == 16'd5) begin
            desc.kind = gatd_pkg::K_F32;
            desc.word = {32'h0, fin_acc[31:0]};
          end else if (fin_len == 16'd9) begin
            desc.kind = gatd_pkg::K_F64;
            desc.word = fin_acc;
          end
        end
        gatd_pkg::TAG_BITS: begin
          if (fin_len <= 16'd5) begin
            desc.kind = gatd_pkg::K_BITS;
            desc.word = fin_acc;
          end
        end
        gatd_pkg::TAG_ARRAY, gatd_pkg::TAG_OCTET, gatd_pkg::TAG_VIS, gatd_pkg::TAG_UNI: begin
          desc.kind = (tag == gatd_pkg::TAG_ARRAY) ? gatd_pkg::K_ARRAY :
                      (tag == gatd_pkg::TAG_OCTET) ? gatd_pkg::K_OCTET :
                      (tag == gatd_pkg::TAG_VIS) ? gatd_pkg::K_VIS : gatd_pkg::K_UNI;
          desc.is_str = 1'b1;
          desc.kept = (fin_len < 16'(MAX_STRING_BYTES - 1)) ?
                      gatd_pkg::KEPT_W'(fin_len) : gatd_pkg::KEPT_W'(MAX_STRING_BYTES - 1);
        end
        default: desc.valid = 1'b0;  // unknown tag, skipped
      endcase
    end

    if (req.frame_end) begin
      if (!discard_next && phase_next != PH_TAG) begin
        desc.valid = 1'b1;
        desc.kind = gatd_pkg::K_TRUNC;
      end
      if (!desc.valid) begin
        desc.valid = 1'b1;
        desc.kind = gatd_pkg::K_NONE;
      end
      desc.done = 1'b1;
      phase_next = PH_TAG; lbl_next = '0; cl_next = '0; cs_next = '0;
      acc_next = '0; sf_next = 1'b0; discard_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TAG; tag <= '0; lbl <= '0; cl <= '0; cs <= '0;
      acc <= '0; sf <= 1'b0; discard <= 1'b0;
    end else if (fire) begin
      phase <= phase_next; tag <= tag_next; lbl <= lbl_next; cl <= cl_next;
      cs <= cs_next; acc <= acc_next; sf <= sf_next; discard <= discard_next;
    end
  end

endmodule

/* sv/gatd_emitter.sv */
// gatd_emitter: string store memory, result sequencer and output register
// depends on gatd_pkg; fed by gatd_parser
module gatd_emitter #(
  parameter int MAX_STRING_BYTES = gatd_pkg::MAX_STRING_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  gatd_pkg::desc_t desc,
  input  gatd_pkg::wr_t   wr,
  output logic            req_ready,
  output logic            res_valid,
  input  logic            res_ready,
  output gatd_pkg::res_t  res_data
);

  localparam int STR_WORDS = (MAX_STRING_BYTES + 7) / 8;
  localparam int WIDX_W = (STR_WORDS > 1) ? $clog2(STR_WORDS) : 1;

  logic [63:0]       mem [STR_WORDS];
  logic [63:0]       rdata;
  gatd_pkg::desc_t   dq;
  logic              dv, primed, move, last, load;
  logic [WIDX_W-1:0] wcnt, rd_idx;
  logic [63:0]       masked;

  assign last = !dq.is_str || (wcnt == WIDX_W'(STR_WORDS - 1));
  assign move = dv && (!res_valid || res_ready) && (!dq.is_str || primed);
  assign req_ready = !dv || (move && last);
  assign load = fire && desc.valid;
  assign rd_idx = (move && !last) ? wcnt + WIDX_W'(1) : wcnt;

  always_comb begin
    for (int j = 0; j < 8; j++)
      masked[8*j +: 8] = (gatd_pkg::KEPT_W'({wcnt, 3'(j)}) < dq.kept) ? rdata[8*j +: 8] : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr[3 +: WIDX_W]][{wr.addr[2:0], 3'b000} +: 8] <= wr.data;
    rdata <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= 1'b0; primed <= 1'b0; wcnt <= '0; res_valid <= 1'b0;
    end else begin
      if (move) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      if (load) begin
        dv <= 1'b1; wcnt <= '0; primed <= 1'b0;
      end else begin
        primed <= dv;
        if (move) begin
          if (last) dv <= 1'b0;
          else wcnt <= wcnt + WIDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) dq <= desc;
    if (move) begin
      res_data.value_kind <= dq.kind;
      res_data.value_word <= dq.is_str ? masked : dq.word;
      res_data.word_index <= dq.is_str ? 6'(wcnt) : 6'd0;
      res_data.run_last   <= last;
      res_data.data_done  <= dq.done && last;
    end
  end

endmodule

/* sv/goose_alldata_tlv_decoder_unit.sv */
// goose_alldata_tlv_decoder_unit: top level of the goose alldata tlv decoder
// depends on gatd_pkg, gatd_parser, gatd_emitter
//
// Decodes the content bytes of a goose allData field, one request per byte,
// into typed result items. A byte is taken every cycle while results drain;
// a byte that ends an element is passed to a one-entry result stage, and the
// next byte is taken in the cycle that stage empties into the output register.
// Scalars, structs and errors give one result, so while results drain bytes
// flow at one per cycle. Strings keep up to MAX_STRING_BYTES-1 bytes, the rest
// reads as zero; a string completion gives (MAX_STRING_BYTES+7)/8 word results
// from the string store memory, read through a register, one word per cycle
// while results drain, and the request side is held until the last one is out.
module goose_alldata_tlv_decoder_unit #(
  parameter int MAX_STRING_BYTES = gatd_pkg::MAX_STRING_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  gatd_pkg::req_t req_data,
  output logic           res_valid,
  input  logic           res_ready,
  output gatd_pkg::res_t res_data
);

  gatd_pkg::desc_t desc;
  gatd_pkg::wr_t   wr;
  logic            fire;

  // a request is taken when both sides agree
  assign fire = req_valid && req_ready;

  // per-byte parse state and decode
  gatd_parser #(.MAX_STRING_BYTES(MAX_STRING_BYTES)) u_parser (
    .clk(clk), .rst(rst), .fire(fire), .req(req_data), .desc(desc), .wr(wr)
  );

  // string memory plus result sequencing
  gatd_emitter #(.MAX_STRING_BYTES(MAX_STRING_BYTES)) u_emitter (
    .clk(clk), .rst(rst), .fire(fire), .desc(desc), .wr(wr),
    .req_ready(req_ready), .res_valid(res_valid), .res_ready(res_ready),
    .res_data(res_data)
  );

endmodule

/* sv/gatd_checker.sv */
// gatd_checker: port-level checks of the goose alldata tlv decoder
// depends on gatd_pkg; bound to goose_alldata_tlv_decoder_unit
module gatd_checker (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_ready,
  input gatd_pkg::res_t res_data
);

  a_rst_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.data_done |-> res_data.run_last)
    else $error("frame done without run end");

  a_zero_word: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.value_kind == gatd_pkg::K_NONE ||
                  res_data.value_kind == gatd_pkg::K_STRUCT ||
                  res_data.value_kind == gatd_pkg::K_LENERR ||
                  res_data.value_kind == gatd_pkg::K_TRUNC)
    |-> res_data.value_word == 64'd0 && res_data.word_index == 6'd0)
    else $error("nonzero word on a kind without value");

endmodule

bind goose_alldata_tlv_decoder_unit gatd_checker u_gatd_checker (.*);
